/* sv/assert_macros.svh */
// Assertion macros for the RTL of the enveloped tone mixer; only the top level includes them.
// Depends on nothing; synthesis builds define SYNTHESIS to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/etm_pkg.sv */
// Shared widths, types and register codes of the enveloped tone mixer.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package etm_pkg;

    localparam int POS_W      = 13;
    localparam int SAMPLE_W   = 16;
    localparam int DUR_W      = 13;
    localparam int BUFLEN_W   = 14;
    localparam int PHASE_W    = 32;
    localparam int AMP_W      = 15;
    localparam int ENV_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 32;
    localparam int TERM_SHIFT = 22;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START    = 3'd0,
        CFG_DURATION = 3'd1,
        CFG_BUFLEN   = 3'd2,
        CFG_STEP     = 3'd3,
        CFG_AMP      = 3'd4
    } t_cfg_idx;

endpackage
`default_nettype wire

/* sv/etm_sine_rom.sv */
// Registered Q15 sine lookup for the tone mixer; the table is built at elaboration.
// Depends on etm_pkg.
`default_nettype none
module etm_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0]   i_addr,
    output etm_pkg::t_sample                           o_sine
);
    import etm_pkg::*;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Quadrant fold, then an odd Taylor series in unsigned Q30.
    function automatic t_sample sine_entry(input logic [31:0] k);
        logic [63:0] k4;
        logic [63:0] quad;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] mag;
        k4   = 64'(k) << 2;
        quad = (k4 / SINE_TABLE_DEPTH) & 64'd3;
        t    = ((k4 % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
        if (quad[0]) begin
            t = Q30_ONE - t;
        end
        x   = (t * Q30_HALF_PI) >> 30;
        x2  = (x * x) >> 30;
        p   = Q30_ONE - x2 / 110;
        p   = Q30_ONE - ((x2 * p) >> 30) / 72;
        p   = Q30_ONE - ((x2 * p) >> 30) / 42;
        p   = Q30_ONE - ((x2 * p) >> 30) / 20;
        p   = Q30_ONE - ((x2 * p) >> 30) / 6;
        x   = (x * p) >> 30;
        mag = (x * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return quad[1] ? -$signed(SAMPLE_W'(mag)) : $signed(SAMPLE_W'(mag));
    endfunction

    t_sample w_rom [SINE_TABLE_DEPTH];
    t_sample r_sine;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = sine_entry(32'(g));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= w_rom[i_addr];
        end
    end

    assign o_sine = r_sine;

endmodule
`default_nettype wire

/* sv/etm_env.sv */
// Linear fade envelope (Q7, 0..128) over three pipeline stages.
// Depends on etm_pkg.
`default_nettype none
module etm_env #(
    parameter int FADE_SAMPLES = 128
) (
    input  wire logic                          i_clk,
    input  wire logic [2:0]                    i_en,      // stages two to four
    input  wire logic [etm_pkg::POS_W-1:0]     i_idx,
    input  wire logic [etm_pkg::DUR_W-1:0]     i_duration,
    output logic      [etm_pkg::ENV_W-1:0]     o_env
);
    import etm_pkg::*;

    localparam int NW   = $clog2(FADE_SAMPLES + 1);
    localparam int MW   = NW + 7;
    localparam int PW   = 2 * MW + 1;
    localparam int CW   = DUR_W + 2;
    localparam int RECIP = (1 << MW) / FADE_SAMPLES;

    logic [NW-1:0]  r_n2;
    logic [MW-1:0]  r_m3;
    logic [PW-1:0]  r_mr3;
    logic [ENV_W-1:0] r_env4;

    logic           w_fade_in;
    logic           w_fade_out;
    logic [NW-1:0]  w_n;
    logic [MW-1:0]  w_m;
    logic [MW:0]    w_q0;
    logic [PW-1:0]  w_qf;
    logic [MW:0]    w_rem;

    // Fade-in wins over fade-out for short tones.
    assign w_fade_in  = CW'(i_idx) < CW'(FADE_SAMPLES);
    assign w_fade_out = (CW'(i_idx) + CW'(FADE_SAMPLES)) > CW'(i_duration);
    assign w_n = w_fade_in  ? NW'(i_idx) :
                 w_fade_out ? NW'(i_duration - i_idx) : NW'(FADE_SAMPLES);

    assign w_m = {r_n2, 7'b0};

    // Reciprocal estimate is low by at most one; fix with a compare.
    assign w_q0  = r_mr3[MW +: MW + 1];
    assign w_qf  = PW'(w_q0) * PW'(FADE_SAMPLES);
    assign w_rem = (MW + 1)'(r_m3) - w_qf[MW:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_n2 <= w_n;
        end
        if (i_en[1]) begin
            r_m3  <= w_m;
            r_mr3 <= PW'(w_m) * PW'(RECIP);
        end
        if (i_en[2]) begin
            r_env4 <= ENV_W'(w_q0) + ENV_W'(w_rem >= (MW + 1)'(FADE_SAMPLES));
        end
    end

    assign o_env = r_env4;

endmodule
`default_nettype wire

/* sv/etm_mixer.sv */
// Tone scaling, add and int16 saturation: the last three pipeline stages.
// Depends on etm_pkg.
`default_nettype none
module etm_mixer (
    input  wire logic                          i_clk,
    input  wire logic [2:0]                    i_en,      // stages five to seven
    input  wire logic [etm_pkg::AMP_W-1:0]     i_amplitude,
    input  wire etm_pkg::t_sample              i_sine,
    input  wire logic [etm_pkg::ENV_W-1:0]     i_env,
    input  wire etm_pkg::t_sample              i_base,
    input  wire logic                          i_win,
    output etm_pkg::t_sample                   o_mixed,
    output logic                               o_clipped
);
    import etm_pkg::*;

    localparam int AS_W   = 2 * SAMPLE_W;
    localparam int PROD_W = AS_W + ENV_W + 1;
    localparam int TERM_W = PROD_W - TERM_SHIFT;
    localparam int SUM_W  = TERM_W + 1;

    logic signed [AS_W-1:0]   r_as5;
    logic [ENV_W-1:0]         r_env5;
    t_sample                  r_base5;
    logic                     r_win5;
    logic signed [PROD_W-1:0] r_prod6;
    t_sample                  r_base6;
    logic                     r_win6;
    t_sample                  r_mixed7;
    logic                     r_clip7;

    logic signed [PROD_W-1:0] w_bias;
    logic signed [PROD_W-1:0] w_biased;
    logic signed [TERM_W-1:0] w_term;
    logic signed [SUM_W-1:0]  w_sum;
    t_sample                  n_mixed;
    logic                     n_clip;

    // Bias negative products so the shift truncates toward zero.
    assign w_bias   = r_prod6[PROD_W-1] ? PROD_W'((1 << TERM_SHIFT) - 1) : '0;
    assign w_biased = r_prod6 + w_bias;
    assign w_term   = w_biased[PROD_W-1:TERM_SHIFT];
    assign w_sum    = SUM_W'(r_base6) + SUM_W'(w_term);

    always_comb begin
        n_mixed = r_base6;
        n_clip  = 1'b0;
        if (r_win6) begin
            if (w_sum > SUM_W'(SAMPLE_MAX)) begin
                n_mixed = SAMPLE_W'(SAMPLE_MAX);
                n_clip  = 1'b1;
            end else if (w_sum < SUM_W'(SAMPLE_MIN)) begin
                n_mixed = SAMPLE_W'(SAMPLE_MIN);
                n_clip  = 1'b1;
            end else begin
                n_mixed = SAMPLE_W'(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_as5   <= AS_W'($signed({1'b0, i_amplitude})) * AS_W'(i_sine);
            r_env5  <= i_env;
            r_base5 <= i_base;
            r_win5  <= i_win;
        end
        if (i_en[1]) begin
            r_prod6 <= PROD_W'(r_as5) * PROD_W'($signed({1'b0, r_env5}));
            r_base6 <= r_base5;
            r_win6  <= r_win5;
        end
        if (i_en[2]) begin
            r_mixed7 <= n_mixed;
            r_clip7  <= n_clip;
        end
    end

    assign o_mixed   = r_mixed7;
    assign o_clipped = r_clip7;

endmodule
`default_nettype wire

/* sv/enveloped_tone_mixer_top.sv */
// Enveloped tone mixer: adds a faded sine tone to a stream of 16-bit samples.
// Channels: slave stream in (position, base sample), master stream out
// (mixed sample, clip flag in tuser), and a register write channel.
// Registers: 0 start position, 1 duration, 2 buffer length, 3 phase step,
// 4 amplitude; writes to other indexes are dropped. Write them only while idle.
// Throughput: one sample per clock while i_m_tready does not stall the output,
// through the seven-stage pipeline (window check, phase multiply, table address,
// sine lookup, amplitude multiply, envelope multiply, add and saturate).
// Each stage has its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles close up and the block keeps taking samples
// while a finished result waits. Under a full stall every stage holds; nothing
// is dropped or repeated.
// Reset (synchronous, active low) clears every valid bit and every config
// register to zero, so until written the tone window is empty and samples pass
// unchanged.
// Mixed sample = base + amplitude*sine*envelope/2^22, saturated to int16.
`default_nettype none
`include "assert_macros.svh"
module enveloped_tone_mixer_top #(
    parameter int FADE_SAMPLES     = 128,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Slave stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [12:0] position, [28:13] base_sample, [31:29] zero
    input  wire logic [etm_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // Master stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [15:0] mixed_sample
    output logic [etm_pkg::SAMPLE_W-1:0]             o_m_tdata,
    // [0] clipped
    output logic                                     o_m_tuser,
    // Register write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [etm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [etm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import etm_pkg::*;

    localparam int NSTG = 7;
    localparam int AW   = $clog2(SINE_TABLE_DEPTH);
    localparam int KPW  = PHASE_W + AW + 1;

    // Configuration registers
    logic [POS_W-1:0]    r_start;
    logic [DUR_W-1:0]    r_duration;
    logic [BUFLEN_W-1:0] r_buflen;
    logic [PHASE_W-1:0]  r_step;
    logic [AMP_W-1:0]    r_amp;

    // Pipeline control
    logic [NSTG:1] r_v;
    logic [NSTG:1] w_en;

    // Stage payloads
    logic [POS_W-1:0]   r_idx1;
    t_sample            r_base1, r_base2, r_base3, r_base4;
    logic               r_win1, r_win2, r_win3, r_win4;
    logic [PHASE_W-1:0] r_phase2;
    logic [AW-1:0]      r_addr3;

    logic [POS_W-1:0]   w_pos;
    t_sample            w_base;
    logic               w_win;
    logic [KPW-1:0]     w_kprod;
    t_sample            w_sine4;
    logic [ENV_W-1:0]   w_env4;
    t_sample            w_mixed;
    logic               w_clip;
    logic               w_on_rail;

    assign w_pos  = i_s_tdata[POS_W-1:0];
    assign w_base = i_s_tdata[POS_W +: SAMPLE_W];

    // In-window test: start <= pos < start+duration and pos < buffer length.
    assign w_win = (w_pos >= r_start) &&
                   ((DUR_W + 1)'(w_pos) < (DUR_W + 1)'(r_start) + (DUR_W + 1)'(r_duration)) &&
                   (BUFLEN_W'(w_pos) < r_buflen);

    // Table index: top bits of phase scaled by the table depth.
    assign w_kprod = KPW'(r_phase2) * KPW'(SINE_TABLE_DEPTH);

    // A stage advances when empty or when the next one advances.
    always_comb begin
        w_en[NSTG] = !r_v[NSTG] || i_m_tready;
        for (int s = NSTG - 1; s >= 1; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_s_tready  = w_en[1];
    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_duration <= '0;
            r_buflen   <= '0;
            r_step     <= '0;
            r_amp      <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_START:    r_start    <= i_cfg_data[POS_W-1:0];
                CFG_DURATION: r_duration <= i_cfg_data[DUR_W-1:0];
                CFG_BUFLEN:   r_buflen   <= i_cfg_data[BUFLEN_W-1:0];
                CFG_STEP:     r_step     <= i_cfg_data[PHASE_W-1:0];
                CFG_AMP:      r_amp      <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_s_tvalid;
            end
            for (int s = 2; s <= NSTG; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // Stages one to four of the datapath held here.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_idx1  <= w_pos - r_start;
            r_base1 <= w_base;
            r_win1  <= w_win;
        end
        if (w_en[2]) begin
            r_phase2 <= PHASE_W'(r_idx1) * r_step;
            r_base2  <= r_base1;
            r_win2   <= r_win1;
        end
        if (w_en[3]) begin
            r_addr3 <= w_kprod[PHASE_W +: AW];
            r_base3 <= r_base2;
            r_win3  <= r_win2;
        end
        if (w_en[4]) begin
            r_base4 <= r_base3;
            r_win4  <= r_win3;
        end
    end

    etm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_en[4]),
        .i_addr (r_addr3),
        .o_sine (w_sine4)
    );

    etm_env #(
        .FADE_SAMPLES (FADE_SAMPLES)
    ) u_env (
        .i_clk      (i_clk),
        .i_en       (w_en[4:2]),
        .i_idx      (r_idx1),
        .i_duration (r_duration),
        .o_env      (w_env4)
    );

    etm_mixer u_mix (
        .i_clk       (i_clk),
        .i_en        (w_en[7:5]),
        .i_amplitude (r_amp),
        .i_sine      (w_sine4),
        .i_env       (w_env4),
        .i_base      (r_base4),
        .i_win       (r_win4),
        .o_mixed     (w_mixed),
        .o_clipped   (w_clip)
    );

    assign o_m_tvalid = r_v[NSTG];
    assign o_m_tdata  = w_mixed;
    assign o_m_tuser  = w_clip;

    assign w_on_rail = (o_m_tdata == 16'h7fff) || (o_m_tdata == 16'h8000);

    // Input is refused only when every stage holds an item.
    `ASSERT_IMPL(a_full_when_refused, i_clk, i_rst_n, !o_s_tready, &r_v)
    // Output taken means the whole pipe can move.
    `ASSERT_IMPL(a_ready_on_drain, i_clk, i_rst_n, i_m_tready, o_s_tready)
    // An accepted sample lands in stage one.
    `ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v[1])
    // A clipped result sits on a rail.
    `ASSERT_IMPL(a_clip_on_rail, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, w_on_rail)

endmodule
`default_nettype wire
